// File: sv/mps_pkg.sv
// Shared constants, codes and controller/datapath types for the split selector.
package mps_pkg;

	localparam int MAX_POSITIONS = 32;
	localparam int MAX_CHARS     = 256;
	localparam int SLOTS         = 4;
	localparam int POS_W         = $clog2(MAX_POSITIONS);
	localparam int CHR_W         = $clog2(MAX_CHARS);
	localparam int CNT_W         = POS_W + 1;
	localparam int SIZE_W        = CHR_W + 1;
	localparam int TOTAL_W       = 33;
	localparam int IDX_W         = 32;
	localparam int SLOT_W        = 2;
	localparam int REGIDX_W      = 8;
	localparam int CFG_W         = 32;

	localparam logic [TOTAL_W-1:0] START_DIST = TOTAL_W'(32'h7fffffff);
	localparam logic signed [5:0] NONE_POS = -6'sd1;

	typedef enum logic [1:0] {
		OP_LOAD_SIZE = 2'd0,
		OP_LOAD_CHAR = 2'd1,
		OP_RUN       = 2'd2,
		OP_QUERY     = 2'd3
	} mps_op_t;

	localparam logic [REGIDX_W-1:0] REG_POS_COUNT = 8'd0;
	localparam logic [REGIDX_W-1:0] REG_TARGET    = 8'd1;
	localparam logic [REGIDX_W-1:0] REG_LIMIT     = 8'd2;
	localparam logic [REGIDX_W-1:0] REG_STACKED   = 8'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RUN_INIT,
		ST_MUL,
		ST_CMP,
		ST_NEXT,
		ST_RUN_END,
		ST_Q_CHECK,
		ST_DIV,
		ST_RD,
		ST_RD_WAIT,
		ST_RESP
	} mps_state_t;

	typedef struct packed {
		logic accept;
		logic run_init;
		logic mul;
		logic cmp;
		logic next;
		logic run_end;
		logic q_start;
		logic div;
		logic rd;
		logic capture;
		logic out_load;
	} mps_ctl_t;

	typedef struct packed {
		logic target_zero;
		logic n_zero;
		logic k_last;
		logic comb_done;
		logic q_skip;
		logic div_last;
		logic t_zero;
		logic out_free;
	} mps_stat_t;

endpackage

// File: sv/mps_ifs.sv
// Request, response and configuration channel interfaces.
interface mps_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [4:0]  position;
	logic [7:0]  slot;
	logic [7:0]  char_value;
	logic [8:0]  range_size;
	logic [31:0] cand_index;
	modport source (output valid, cmd, position, slot, char_value, range_size, cand_index,
		input ready);
	modport sink (input valid, cmd, position, slot, char_value, range_size, cand_index,
		output ready);
endinterface

interface mps_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [5:0]  sel0;
	logic signed [5:0]  sel1;
	logic signed [5:0]  sel2;
	logic signed [5:0]  sel3;
	logic signed [5:0]  last_selected;
	logic [32:0]        cand_total;
	logic               is_static;
	logic [7:0]         ch0;
	logic [7:0]         ch1;
	logic [7:0]         ch2;
	logic [7:0]         ch3;
	modport source (output valid, sel0, sel1, sel2, sel3, last_selected, cand_total,
		is_static, ch0, ch1, ch2, ch3, input ready);
	modport sink (input valid, sel0, sel1, sel2, sel3, last_selected, cand_total,
		is_static, ch0, ch1, ch2, ch3, output ready);
endinterface

interface mps_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/mask_position_split_selector.sv
// Top level of the mask position split selector.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | cmd, position, slot, char_value, range_size, cand_index
//  rsp     | out | valid/ready   | sel0..sel3, last_selected, cand_total, is_static, ch0..ch3
//  cfg     | in  | valid/ready   | index, data (ready always high)
//
// A run steps one shared 33x9 multiplier through each combination of positions
// and compares each product with the target; a zero target skips the search.
// A query runs a 32-step restoring divider per digit of each selected position,
// followed by a registered character store read.
// Reset is asynchronous; the character and size stores are not cleared.
// A finished result waits in the output register while the next request is taken.
module mask_position_split_selector (
	input  logic      clk,
	input  logic      arst_n,
	mps_req_if.sink   req,
	mps_rsp_if.source rsp,
	mps_cfg_if.sink   cfg
);
	import mps_pkg::*;

	mps_ctl_t  ctl;
	mps_stat_t stat;

	mps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	mps_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cmd        (req.cmd),
		.position   (req.position),
		.slot       (req.slot),
		.char_value (req.char_value),
		.range_size (req.range_size),
		.cand_index (req.cand_index),
		.cfg        (cfg),
		.rsp        (rsp)
	);

endmodule

// File: sv/mps_ctrl.sv
// Controller state machine sequencing loads, search and query.
module mps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_cmd,
	output logic               req_ready,
	input  mps_pkg::mps_stat_t stat,
	output mps_pkg::mps_ctl_t  ctl
);
	import mps_pkg::*;

	mps_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					unique case (mps_op_t'(req_cmd))
						OP_LOAD_SIZE, OP_LOAD_CHAR: state_nxt = ST_RESP;
						OP_RUN:                     state_nxt = ST_RUN_INIT;
						OP_QUERY:                   state_nxt = ST_Q_CHECK;
					endcase
				end
			end
			ST_RUN_INIT: begin
				ctl.run_init = 1'b1;
				if (stat.target_zero) state_nxt = ST_RESP;
				else if (stat.n_zero) state_nxt = ST_RUN_END;
				else state_nxt = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				if (stat.k_last) state_nxt = ST_CMP;
			end
			ST_CMP: begin
				ctl.cmp = 1'b1;
				state_nxt = ST_NEXT;
			end
			ST_NEXT: begin
				ctl.next = 1'b1;
				state_nxt = stat.comb_done ? ST_RUN_END : ST_MUL;
			end
			ST_RUN_END: begin
				ctl.run_end = 1'b1;
				state_nxt = ST_RESP;
			end
			ST_Q_CHECK: begin
				ctl.q_start = 1'b1;
				state_nxt = stat.q_skip ? ST_RESP : ST_DIV;
			end
			ST_DIV: begin
				ctl.div = 1'b1;
				if (stat.div_last) state_nxt = ST_RD;
			end
			ST_RD: begin
				ctl.rd = 1'b1;
				state_nxt = ST_RD_WAIT;
			end
			ST_RD_WAIT: begin
				ctl.capture = 1'b1;
				state_nxt = stat.t_zero ? ST_RESP : ST_DIV;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// File: sv/mps_dp.sv
// Datapath: stores, config registers, combination walker, divider and output register.
module mps_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mps_pkg::mps_ctl_t  ctl,
	output mps_pkg::mps_stat_t stat,
	input  logic [1:0]         cmd,
	input  logic [4:0]         position,
	input  logic [7:0]         slot,
	input  logic [7:0]         char_value,
	input  logic [8:0]         range_size,
	input  logic [31:0]        cand_index,
	mps_cfg_if.sink            cfg,
	mps_rsp_if.source          rsp
);
	import mps_pkg::*;

	// configuration
	logic [CNT_W-1:0] pos_count_q;
	logic [30:0]      target_q;
	logic [5:0]       limit_q;
	logic             stacked_q;

	// stores
	logic [SIZE_W-1:0] size_mem [MAX_POSITIONS];
	logic [CHR_W-1:0]  char_mem [MAX_POSITIONS*MAX_CHARS];
	logic [CHR_W-1:0]  rdata_q;

	// selection state
	logic signed [5:0]   sel_q [SLOTS];
	logic signed [5:0]   last_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                static_q;
	logic [SIZE_W-1:0]   lsize_q [SLOTS];

	// walker
	logic [POS_W-1:0]    c_q [SLOTS];
	logic [POS_W-1:0]    nc [SLOTS];
	logic [2:0]          r_q;
	logic [SLOT_W-1:0]   k_q;
	logic [TOTAL_W-1:0]  prod_q;
	logic [SIZE_W-1:0]   csz_q [SLOTS];
	logic [TOTAL_W-1:0]  best_q;
	logic [CNT_W-1:0]    n;
	logic [SIZE_W-1:0]   size_rd;
	logic [TOTAL_W-1:0]  gap;
	logic                found;
	logic [SLOT_W-1:0]   jsel;
	logic [SLOT_W-1:0]   rlast;

	// query
	logic [IDX_W-1:0]    idx_q;
	logic [SLOT_W-1:0]   t_q;
	logic [4:0]          cnt_q;
	logic [SIZE_W-1:0]   rem_q;
	logic [SIZE_W:0]     rem_sh;
	logic [SIZE_W-1:0]   divisor;
	logic                take;
	logic [SLOT_W-1:0]   t_top;
	logic [CHR_W-1:0]    ch_q [SLOTS];
	logic [POS_W+CHR_W-1:0] raddr;
	logic                stat_new;

	// output stage
	logic                out_valid_q;
	logic signed [5:0]   o_sel_q [SLOTS];
	logic signed [5:0]   o_last_q;
	logic [TOTAL_W-1:0]  o_total_q;
	logic                o_static_q;
	logic [CHR_W-1:0]    o_ch_q [SLOTS];

	assign cfg.ready = 1'b1;
	assign n = (pos_count_q > CNT_W'(MAX_POSITIONS)) ? CNT_W'(MAX_POSITIONS) : pos_count_q;
	assign size_rd = size_mem[c_q[k_q]];
	assign gap = (prod_q >= TOTAL_W'(target_q)) ? prod_q - TOTAL_W'(target_q)
		: TOTAL_W'(target_q) - prod_q;
	assign rlast = SLOT_W'(r_q - 3'd1);
	assign divisor = lsize_q[t_q];
	assign rem_sh = {rem_q, idx_q[IDX_W-1]};
	assign take = rem_sh >= {1'b0, divisor};
	assign raddr = {sel_q[t_q][POS_W-1:0], rem_q[CHR_W-1:0]};

	// rightmost index that can still advance
	always_comb begin
		found = 1'b0;
		jsel = '0;
		for (int j = 0; j < SLOTS; j++) begin
			if (3'(j) < r_q && {3'b0, c_q[j]} <
				({2'b0, n} - {5'b0, r_q} + (CNT_W + 2)'(j))) begin
				found = 1'b1;
				jsel = SLOT_W'(j);
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (SLOT_W'(i) < jsel) nc[i] = c_q[i];
			else nc[i] = POS_W'(c_q[jsel] + POS_W'(i) - POS_W'(jsel) + POS_W'(1));
		end
	end

	always_comb begin
		if (!sel_q[3][5]) t_top = 2'd3;
		else if (!sel_q[2][5]) t_top = 2'd2;
		else if (!sel_q[1][5]) t_top = 2'd1;
		else t_top = 2'd0;
		stat_new = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!sel_q[i][5] && {1'b0, sel_q[i][4:0]} >= limit_q) stat_new = 1'b0;
		end
		if (!stacked_q) stat_new = 1'b1;
	end

	always_comb begin
		stat.target_zero = (target_q == '0);
		stat.n_zero = (n == '0);
		stat.k_last = (k_q == rlast);
		stat.comb_done = !found && (r_q == 3'(SLOTS) || {3'b0, r_q} >= n);
		stat.q_skip = sel_q[0][5] || ({1'b0, idx_q} >= total_q);
		stat.div_last = (cnt_q == 5'd31);
		stat.t_zero = (t_q == '0);
		stat.out_free = !out_valid_q || rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_count_q <= '0;
			target_q <= '0;
			limit_q <= '0;
			stacked_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_POS_COUNT: pos_count_q <= cfg.data[CNT_W-1:0];
				REG_TARGET:    target_q <= cfg.data[30:0];
				REG_LIMIT:     limit_q <= cfg.data[5:0];
				REG_STACKED:   stacked_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && mps_op_t'(cmd) == OP_LOAD_SIZE) begin
			size_mem[position] <= (range_size > SIZE_W'(MAX_CHARS)) ? SIZE_W'(MAX_CHARS)
				: range_size;
		end
		if (ctl.accept && mps_op_t'(cmd) == OP_LOAD_CHAR) begin
			char_mem[{position, slot}] <= char_value;
		end
		if (ctl.rd) rdata_q <= char_mem[raddr];
	end

	// selection state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				sel_q[i] <= NONE_POS;
				lsize_q[i] <= '0;
			end
			last_q <= NONE_POS;
			total_q <= TOTAL_W'(1);
			static_q <= 1'b0;
		end else if (ctl.run_init) begin
			for (int i = 0; i < SLOTS; i++) begin
				sel_q[i] <= NONE_POS;
				lsize_q[i] <= '0;
			end
			last_q <= NONE_POS;
			total_q <= TOTAL_W'(1);
		end else if (ctl.cmp && gap < best_q) begin
			for (int i = 0; i < SLOTS; i++) begin
				sel_q[i] <= (3'(i) < r_q) ? $signed({1'b0, c_q[i]}) : NONE_POS;
				lsize_q[i] <= (3'(i) < r_q) ? csz_q[i] : '0;
			end
			last_q <= $signed({1'b0, c_q[rlast]});
			total_q <= prod_q;
		end else if (ctl.run_end) begin
			static_q <= stat_new;
		end
	end

	// walker and divider working registers, query characters and output data registers
	always_ff @(posedge clk) begin
		if (ctl.run_init) begin
			r_q <= 3'd1;
			for (int i = 0; i < SLOTS; i++) c_q[i] <= POS_W'(i);
			k_q <= '0;
			prod_q <= TOTAL_W'(1);
			best_q <= START_DIST;
		end
		if (ctl.mul) begin
			prod_q <= TOTAL_W'(prod_q * size_rd);
			csz_q[k_q] <= size_rd;
			k_q <= k_q + SLOT_W'(1);
		end
		if (ctl.cmp && gap < best_q) best_q <= gap;
		if (ctl.next) begin
			if (found) begin
				for (int i = 0; i < SLOTS; i++) c_q[i] <= nc[i];
			end else begin
				r_q <= r_q + 3'd1;
				for (int i = 0; i < SLOTS; i++) c_q[i] <= POS_W'(i);
			end
			k_q <= '0;
			prod_q <= TOTAL_W'(1);
		end
		if (ctl.accept) begin
			idx_q <= cand_index;
			for (int i = 0; i < SLOTS; i++) ch_q[i] <= '0;
		end
		if (ctl.q_start) begin
			t_q <= t_top;
			cnt_q <= '0;
			rem_q <= '0;
		end
		// one restoring division step: remainder is the digit, quotient stays in idx_q
		if (ctl.div) begin
			rem_q <= take ? SIZE_W'(rem_sh - {1'b0, divisor}) : SIZE_W'(rem_sh);
			idx_q <= {idx_q[IDX_W-2:0], take};
			cnt_q <= cnt_q + 5'd1;
		end
		if (ctl.capture) begin
			ch_q[t_q] <= rdata_q;
			if (t_q != '0) begin
				t_q <= t_q - SLOT_W'(1);
				cnt_q <= '0;
				rem_q <= '0;
			end
		end
		if (ctl.out_load) begin
			for (int i = 0; i < SLOTS; i++) begin
				o_sel_q[i] <= sel_q[i];
				o_ch_q[i] <= ch_q[i];
			end
			o_last_q <= last_q;
			o_total_q <= total_q;
			o_static_q <= static_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.sel0 = o_sel_q[0];
	assign rsp.sel1 = o_sel_q[1];
	assign rsp.sel2 = o_sel_q[2];
	assign rsp.sel3 = o_sel_q[3];
	assign rsp.last_selected = o_last_q;
	assign rsp.cand_total = o_total_q;
	assign rsp.is_static = o_static_q;
	assign rsp.ch0 = o_ch_q[0];
	assign rsp.ch1 = o_ch_q[1];
	assign rsp.ch2 = o_ch_q[2];
	assign rsp.ch3 = o_ch_q[3];

endmodule

// File: sv/mps_checker.sv
// Port-level checker for the split selector and its bind.
module mps_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic signed [5:0] sel0,
	input logic signed [5:0] sel1,
	input logic signed [5:0] sel2,
	input logic signed [5:0] sel3,
	input logic signed [5:0] last_selected,
	input logic [32:0]       cand_total
);
	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// an empty selection leaves no later slot filled
	a_empty_sel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && sel0 == -6'sd1 |-> sel1 == -6'sd1 && sel2 == -6'sd1 &&
		sel3 == -6'sd1 && last_selected == -6'sd1)
		else $error("partial empty selection");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && sel0 == -6'sd1 |-> cand_total == 33'd1)
		else $error("empty selection with total not one");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(cand_total))
		else $error("stalled response changed");

endmodule

bind mask_position_split_selector mps_checker u_mps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.sel0          (rsp.sel0),
	.sel1          (rsp.sel1),
	.sel2          (rsp.sel2),
	.sel3          (rsp.sel3),
	.last_selected (rsp.last_selected),
	.cand_total    (rsp.cand_total)
);
